FILE: rtl/core/tce_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package tce_pkg;

	// Default sizes and queue depth
	localparam int DEF_MAX_COLUMNS = 256;
	localparam int DEF_MAX_ROWS    = 64;
	localparam int QUEUE_DEPTH     = 4;
	localparam int LW_RESET        = 80;

	// Request type codes on the input stream
	localparam logic [1:0] REQ_MOVE  = 2'd0;
	localparam logic [1:0] REQ_PUT   = 2'd1;
	localparam logic [1:0] REQ_ERASE = 2'd2;

	// Configuration register indexes
	localparam logic REG_LINE_WIDTH = 1'b0;
	localparam logic REG_TAB_OFFSET = 1'b1;

	// Result operation kinds
	localparam logic OP_CELL  = 1'b0;
	localparam logic OP_CLEAR = 1'b1;

	// Character codes
	localparam logic [15:0] CH_TAB    = 16'h0009;
	localparam logic [15:0] CH_SPACE  = 16'h0020;
	localparam logic [15:0] CH_DOLLAR = 16'h0024;
	localparam logic [15:0] CH_ZERO   = 16'h0030;
	localparam logic [15:0] CH_BSLASH = 16'h005C;
	localparam logic [15:0] CH_CARET  = 16'h005E;
	localparam logic [15:0] CH_DEL    = 16'h007F;
	localparam logic [15:0] CH_META   = 16'h0080;
	localparam logic [15:0] CH_WIDE   = 16'h0100;
	localparam logic [15:0] CTRL_FLIP = 16'h0040;

	localparam logic signed [15:0] COL_MAX = 16'sh7FFF;

	typedef enum logic [1:0] {
		CMD_MOVE,
		CMD_PUT,
		CMD_ERASE,
		CMD_NONE
	} cmd_kind_t;

	// Character classes; CLS_SPACE2 stands for a wide character that does not fit
	typedef enum logic [2:0] {
		CLS_PLAIN,
		CLS_TAB,
		CLS_CTRL,
		CLS_OCT,
		CLS_WIDE,
		CLS_SPACE2
	} char_cls_t;

	typedef struct packed {
		cmd_kind_t   kind;
		char_cls_t   cls;
		logic [5:0]  row;
		logic [15:0] col;
		logic [15:0] code;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage
`default_nettype wire

FILE: rtl/core/tce_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module tce_queue
	import tce_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    push,
	input  wire cmd_t    wr_cmd,
	input  wire logic    pop,
	output cmd_t         rd_cmd,
	output q_stat_t      stat
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	cmd_t             mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign stat.full  = (cnt_q == CNT_W'(QUEUE_DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign rd_cmd     = mem_q[rd_ptr_q];

	// Store the transfer at the write pointer
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

	// Advance pointers and track fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/tce_front.sv
`timescale 1ns / 1ps
`default_nettype none
module tce_front
	import tce_pkg::*;
#(
	parameter int MAX_ROWS = DEF_MAX_ROWS
) (
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [39:0] s_tdata,
	input  wire logic [1:0]  s_tuser,
	input  wire q_stat_t     qstat,
	output logic             push,
	output cmd_t             cmd
);

	localparam int RW = 11;

	logic [5:0]  row_sel;
	logic [15:0] start_col;
	logic [15:0] char_code;

	assign row_sel   = s_tdata[5:0];
	assign start_col = s_tdata[21:6];
	assign char_code = s_tdata[37:22];

	assign s_tready = !qstat.full;
	assign push     = s_tvalid && s_tready;

	// Classify the request and the character, and clamp the row
	always_comb begin
		cmd.code = char_code;
		cmd.col  = start_col;
		if ({5'b0, row_sel} < RW'(MAX_ROWS)) begin
			cmd.row = row_sel;
		end else begin
			cmd.row = 6'(MAX_ROWS - 1);
		end
		case (s_tuser)
			REQ_MOVE:  cmd.kind = CMD_MOVE;
			REQ_PUT:   cmd.kind = CMD_PUT;
			REQ_ERASE: cmd.kind = CMD_ERASE;
			default:   cmd.kind = CMD_NONE;
		endcase
		if (char_code == CH_TAB) begin
			cmd.cls = CLS_TAB;
		end else if (char_code < CH_SPACE || char_code == CH_DEL) begin
			cmd.cls = CLS_CTRL;
		end else if (char_code >= CH_META && char_code < CH_WIDE) begin
			cmd.cls = CLS_OCT;
		end else if (char_code >= CH_WIDE) begin
			cmd.cls = CLS_WIDE;
		end else begin
			cmd.cls = CLS_PLAIN;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/tce_back.sv
`timescale 1ns / 1ps
`default_nettype none
module tce_back
	import tce_pkg::*;
#(
	parameter int MAX_COLUMNS = DEF_MAX_COLUMNS
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_idx,
	input  wire logic [8:0]  cfg_wdata,
	input  wire cmd_t        cmd,
	input  wire q_stat_t     qstat,
	output logic             pop,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,
	output logic [1:0]       m_tuser,
	output logic             m_tlast
);

	localparam logic [15:0] MAXC16  = 16'(MAX_COLUMNS);
	localparam logic [15:0] W_RESET = (LW_RESET > MAX_COLUMNS) ? MAXC16 : 16'(LW_RESET);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_LEAF  = 3'b010,
		ST_TRAIL = 3'b100
	} state_t;

	state_t             state_q, state_d;
	logic [15:0]        weff_q;
	logic [2:0]         tab_off_q;
	logic [5:0]         cur_row_q, row_d;
	logic signed [15:0] cur_col_q, col_d;
	logic               trl_q, trl_d;
	char_cls_t          cls_q, cls_d;
	logic [2:0]         idx_q, idx_d;

	logic               out_valid_q;
	logic               out_kind_q;
	logic               out_trl_q;
	logic               out_last_q;
	logic [5:0]         out_row_q;
	logic [7:0]         out_col_q;
	logic [15:0]        out_val_q;

	logic               slot_free;
	logic signed [15:0] w_s, w_m1, w_m2, col_inc;
	logic               over, neg, final_leaf;
	logic [2:0]         tab_pos;
	logic [15:0]        leaf_val, lw16, lw_clamp;
	logic               emit, e_kind, e_trl, e_last;
	logic [7:0]         e_col;
	logic [15:0]        e_val;

	assign slot_free = !out_valid_q || m_tready;
	assign w_s       = signed'(weff_q);
	assign w_m1      = w_s - 16'sd1;
	assign w_m2      = w_s - 16'sd2;
	assign col_inc   = (cur_col_q == COL_MAX) ? COL_MAX : cur_col_q + 16'sd1;
	assign over      = cur_col_q >= w_s;
	assign neg       = cur_col_q < 16'sd0;
	assign tab_pos   = col_inc[2:0] + tab_off_q;

	// Clamp a written line width to the supported range
	assign lw16     = {7'b0, cfg_wdata};
	assign lw_clamp = (lw16 < 16'd2) ? 16'd2 : ((lw16 > MAXC16) ? MAXC16 : lw16);

	// Pick the character of the current expansion step
	always_comb begin
		case (cls_q)
			CLS_TAB:    leaf_val = CH_SPACE;
			CLS_SPACE2: leaf_val = CH_SPACE;
			CLS_CTRL:   leaf_val = (idx_q == 3'd0) ? CH_CARET : (cmd.code ^ CTRL_FLIP);
			CLS_OCT: begin
				case (idx_q)
					3'd0:    leaf_val = CH_BSLASH;
					3'd1:    leaf_val = CH_ZERO + {13'b0, cmd.code[8:6]};
					3'd2:    leaf_val = CH_ZERO + {13'b0, cmd.code[5:3]};
					default: leaf_val = CH_ZERO + {13'b0, cmd.code[2:0]};
				endcase
			end
			default:    leaf_val = cmd.code;
		endcase
	end

	// Decide whether the current step ends the expansion
	always_comb begin
		case (cls_q)
			CLS_TAB:    final_leaf = (tab_pos == 3'd0) || (idx_q == 3'd7);
			CLS_CTRL:   final_leaf = (idx_q == 3'd1);
			CLS_SPACE2: final_leaf = (idx_q == 3'd1);
			CLS_OCT:    final_leaf = (idx_q == 3'd3);
			default:    final_leaf = 1'b1;
		endcase
	end

	// Sequence commands into cell writes
	always_comb begin
		emit    = 1'b0;
		e_kind  = OP_CELL;
		e_col   = cur_col_q[7:0];
		e_val   = CH_SPACE;
		e_trl   = 1'b0;
		e_last  = 1'b0;
		state_d = state_q;
		row_d   = cur_row_q;
		col_d   = cur_col_q;
		trl_d   = trl_q;
		cls_d   = cls_q;
		idx_d   = idx_q;
		pop     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (!qstat.empty && slot_free) begin
					idx_d = 3'd0;
					case (cmd.kind)
						CMD_MOVE: begin
							row_d = cmd.row;
							col_d = signed'(cmd.col);
							trl_d = 1'b0;
							pop   = 1'b1;
						end
						CMD_ERASE: begin
							if (!over) begin
								emit   = 1'b1;
								e_kind = OP_CLEAR;
								e_col  = neg ? 8'd0 : cur_col_q[7:0];
								e_last = 1'b1;
								col_d  = w_s;
								trl_d  = 1'b0;
							end
							pop = 1'b1;
						end
						CMD_PUT: begin
							state_d = ST_LEAF;
							if (over) begin
								cls_d = CLS_PLAIN;
							end else if (cmd.cls == CLS_WIDE) begin
								if (!neg && cur_col_q < w_m1) begin
									emit    = 1'b1;
									e_val   = cmd.code;
									state_d = ST_TRAIL;
								end else begin
									cls_d = CLS_SPACE2;
								end
							end else begin
								cls_d = cmd.cls;
							end
						end
						default: pop = 1'b1;
					endcase
				end
			end
			ST_LEAF: begin
				if (slot_free) begin
					if (over && trl_q) begin
						// blank the split wide character before the first '$'
						emit  = 1'b1;
						e_col = w_m2[7:0];
						trl_d = 1'b0;
					end else begin
						if (over) begin
							emit   = 1'b1;
							e_col  = w_m1[7:0];
							e_val  = CH_DOLLAR;
							e_last = final_leaf;
						end else if (!neg) begin
							emit   = 1'b1;
							e_val  = leaf_val;
							e_last = final_leaf;
							if (cur_col_q == w_m1) begin
								trl_d = 1'b0;
							end
						end
						col_d = col_inc;
						if (final_leaf) begin
							pop     = 1'b1;
							state_d = ST_IDLE;
						end else begin
							idx_d = idx_q + 3'd1;
						end
					end
				end
			end
			ST_TRAIL: begin
				if (slot_free) begin
					emit    = 1'b1;
					e_col   = cur_col_q[7:0] + 8'd1;
					e_val   = 16'd0;
					e_trl   = 1'b1;
					e_last  = 1'b1;
					trl_d   = (cur_col_q + 16'sd1 == w_m1);
					col_d   = cur_col_q + 16'sd2;
					pop     = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Hold sequencer state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			weff_q    <= W_RESET;
			tab_off_q <= 3'd0;
			cur_row_q <= 6'd0;
			cur_col_q <= 16'sd0;
			trl_q     <= 1'b0;
			cls_q     <= CLS_PLAIN;
			idx_q     <= 3'd0;
		end else begin
			state_q   <= state_d;
			cur_row_q <= row_d;
			cur_col_q <= col_d;
			trl_q     <= trl_d;
			cls_q     <= cls_d;
			idx_q     <= idx_d;
			if (cfg_we) begin
				case (cfg_idx)
					REG_LINE_WIDTH: weff_q    <= lw_clamp;
					REG_TAB_OFFSET: tab_off_q <= cfg_wdata[2:0];
					default: ;
				endcase
			end
		end
	end

	// Output valid: set on a new cell, drop after the transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (emit) begin
			out_kind_q <= e_kind;
			out_trl_q  <= e_trl;
			out_last_q <= e_last;
			out_row_q  <= cur_row_q;
			out_col_q  <= e_col;
			out_val_q  <= e_val;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b0, out_val_q, out_col_q, out_row_q};
	assign m_tuser  = {out_trl_q, out_kind_q};
	assign m_tlast  = out_last_q;

endmodule
`default_nettype wire

FILE: rtl/core/text_cell_expander.sv
`timescale 1ns / 1ps
`default_nettype none
// Text cell expander: turns move, put and erase requests into cell writes for one
// screen line, expanding tabs, caret control codes, octal escapes and wide characters,
// and marking overflow with '$' in the last column. A front end classifies each
// request into a four-entry queue; a back-end sequencer expands it at one cell per
// cycle into a single output register. A move, an erase or an ignored request ends at
// dispatch; a put then expands one cell per step: a plain character, a caret and the
// flipped code, a backslash and three octal digits, up to eight tab spaces, or two
// spaces for a wide character that does not fit. A fitting wide character is written
// at dispatch and its trailer after it; an overflowing put first blanks a split wide
// character. The sequencer stalls while the output register holds an untaken cell. The
// last result of each request carries tlast; a request with no result produces nothing.
module text_cell_expander
	import tce_pkg::*;
#(
	parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
	parameter int MAX_ROWS    = DEF_MAX_ROWS
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [39:0] s_tdata,   // row_sel[5:0], start_col[21:6], char_code[37:22]
	input  wire logic [1:0]  s_tuser,   // req_type[1:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // row_out[5:0], col_out[13:6], cell_value[29:14]
	output logic [1:0]       m_tuser,   // op_kind[0], trailer_mark[1]
	output logic             m_tlast,
	input  wire logic        cfg_we,
	input  wire logic        cfg_idx,
	input  wire logic [8:0]  cfg_wdata
);

	cmd_t    wr_cmd;
	cmd_t    rd_cmd;
	q_stat_t qstat;
	logic    push;
	logic    pop;

	tce_front #(
		.MAX_ROWS(MAX_ROWS)
	) u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.qstat    (qstat),
		.push     (push),
		.cmd      (wr_cmd)
	);

	tce_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_cmd (wr_cmd),
		.pop    (pop),
		.rd_cmd (rd_cmd),
		.stat   (qstat)
	);

	tce_back #(
		.MAX_COLUMNS(MAX_COLUMNS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cmd       (rd_cmd),
		.qstat     (qstat),
		.pop       (pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule
`default_nettype wire

FILE: test/tce_cell_checker.sv
`timescale 1ns / 1ps
module tce_cell_checker
	import tce_pkg::*;
#(
	parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
	parameter int MAX_ROWS    = DEF_MAX_ROWS
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [39:0] s_tdata,   // row_sel[5:0], start_col[21:6], char_code[37:22]
	input  wire logic [1:0]  s_tuser,   // req_type[1:0]
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [31:0] m_tdata,   // row_out[5:0], col_out[13:6], cell_value[29:14]
	input  wire logic [1:0]  m_tuser,   // op_kind[0], trailer_mark[1]
	input  wire logic        m_tlast,
	input  wire logic        cfg_we,
	input  wire logic        cfg_idx,
	input  wire logic [8:0]  cfg_wdata,
	output int               mismatches,
	output int               pending
);

	localparam int MAX_RUN = 9;

	typedef struct packed {
		logic        op;
		logic [5:0]  row;
		logic [7:0]  col;
		logic [15:0] val;
		logic        trl;
		logic        last;
	} cell_wr_t;

	// Cell writes still owed by the block, oldest first
	cell_wr_t   pending_writes[$];
	cell_wr_t   run_writes[$];

	// Shadow of the line state and the registers
	logic [8:0] width_reg;
	logic [2:0] tab_reg;
	logic [5:0] row_q;
	int         col_q;
	logic       split_wide;
	int         err_cnt;

	function automatic int eff_width();
		if (width_reg < 2) return 2;
		if (width_reg > MAX_COLUMNS) return MAX_COLUMNS;
		return int'(width_reg);
	endfunction

	function automatic void add_write(input logic op, input int col, input logic [15:0] val,
			input logic trl);
		cell_wr_t w;
		if (run_writes.size() >= MAX_RUN) return;
		w.op   = op;
		w.row  = row_q;
		w.col  = col[7:0];
		w.val  = val;
		w.trl  = trl;
		w.last = 1'b0;
		run_writes.push_back(w);
	endfunction

	// Advance the column, saturating at the top of the signed range
	function automatic void advance_col(input int n);
		col_q = (col_q + n > int'(COL_MAX)) ? int'(COL_MAX) : col_q + n;
	endfunction

	// Past the line end: '$' in the last column, blanking a split wide char first
	function automatic void mark_overflow();
		int w;
		w = eff_width();
		advance_col(1);
		if (split_wide) begin
			add_write(OP_CELL, w - 2, CH_SPACE, 1'b0);
			split_wide = 1'b0;
		end
		add_write(OP_CELL, w - 1, CH_DOLLAR, 1'b0);
	endfunction

	function automatic void put_glyph(input logic [15:0] c);
		int w;
		w = eff_width();
		if (col_q >= w) begin
			mark_overflow();
			return;
		end
		if (col_q >= 0) begin
			add_write(OP_CELL, col_q, c, 1'b0);
			if (col_q == w - 1) split_wide = 1'b0;
		end
		advance_col(1);
	endfunction

	function automatic void expand_char(input logic [15:0] c);
		int w;
		int n;
		w = eff_width();
		if (col_q >= w) begin
			mark_overflow();
		end else if (c == CH_TAB) begin
			n = 0;
			do begin
				put_glyph(CH_SPACE);
				n++;
			end while ((((col_q + int'(tab_reg)) & 7) != 0) && n < 8);
		end else if (c < CH_SPACE || c == CH_DEL) begin
			put_glyph(CH_CARET);
			put_glyph(c ^ CTRL_FLIP);
		end else if (c >= CH_META && c < CH_WIDE) begin
			put_glyph(CH_BSLASH);
			put_glyph(CH_ZERO + {13'd0, c[8:6]});
			put_glyph(CH_ZERO + {13'd0, c[5:3]});
			put_glyph(CH_ZERO + {13'd0, c[2:0]});
		end else if (c >= CH_WIDE) begin
			if (col_q >= w - 1 || col_q < 0) begin
				put_glyph(CH_SPACE);
				put_glyph(CH_SPACE);
			end else begin
				add_write(OP_CELL, col_q, c, 1'b0);
				add_write(OP_CELL, col_q + 1, 16'd0, 1'b1);
				split_wide = (col_q + 1 == w - 1);
				advance_col(2);
			end
		end else begin
			put_glyph(c);
		end
	endfunction

	// Work out the writes caused by one request and queue them
	function automatic void expand_request(input logic [1:0] req, input logic [5:0] row,
			input logic [15:0] start, input logic [15:0] code);
		int       w;
		cell_wr_t wr;
		w = eff_width();
		run_writes.delete();
		case (req)
			REQ_MOVE: begin
				row_q      = (row < MAX_ROWS) ? row : 6'(MAX_ROWS - 1);
				col_q      = int'($signed(start));
				split_wide = 1'b0;
			end
			REQ_PUT: expand_char(code);
			REQ_ERASE: begin
				if (col_q < w) begin
					add_write(OP_CLEAR, (col_q < 0) ? 0 : col_q, CH_SPACE, 1'b0);
					col_q      = w;
					split_wide = 1'b0;
				end
			end
			default: ;
		endcase
		foreach (run_writes[i]) begin
			wr      = run_writes[i];
			wr.last = (i == run_writes.size() - 1);
			pending_writes.push_back(wr);
		end
	endfunction

	function automatic void check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			err_cnt++;
			$display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
		end
	endfunction

	// Track register writes, predict on input transfers, compare on output transfers
	always @(posedge clk or negedge arst_n) begin : watch_channels
		cell_wr_t got;
		cell_wr_t want;
		if (!arst_n) begin
			width_reg  = 9'(LW_RESET);
			tab_reg    = 3'd0;
			row_q      = 6'd0;
			col_q      = 0;
			split_wide = 1'b0;
			err_cnt    = 0;
			pending_writes.delete();
			mismatches <= 0;
			pending    <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_idx == REG_LINE_WIDTH) width_reg = cfg_wdata;
				else tab_reg = cfg_wdata[2:0];
			end
			if (s_tvalid && s_tready)
				expand_request(s_tuser, s_tdata[5:0], s_tdata[21:6], s_tdata[37:22]);
			if (m_tvalid && m_tready) begin
				got = {m_tuser[0], m_tdata[5:0], m_tdata[13:6], m_tdata[29:14], m_tuser[1],
					m_tlast};
				if (pending_writes.size() == 0) begin
					err_cnt++;
					$display("%0t: unexpected transfer: expected none, actual %h", $time, got);
				end else begin
					want = pending_writes.pop_front();
					check_field("op_kind", 16'(want.op), 16'(got.op));
					check_field("row_out", 16'(want.row), 16'(got.row));
					check_field("col_out", 16'(want.col), 16'(got.col));
					check_field("cell_value", want.val, got.val);
					check_field("trailer_mark", 16'(want.trl), 16'(got.trl));
					check_field("last_of_run", 16'(want.last), 16'(got.last));
				end
			end
			mismatches <= err_cnt;
			pending    <= pending_writes.size();
		end
	end

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
	import tce_pkg::*;

	localparam logic [1:0] REQ_UNUSED     = 2'd3;
	localparam int         DRAIN_CYCLES   = 40;
	localparam int         WATCHDOG_LIMIT = 4000;
	localparam int         PHASE_ITEMS    = 32;
	localparam int         NUM_PHASES     = 8;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata   = '0;   // row_sel[5:0], start_col[21:6], char_code[37:22]
	logic [1:0]  s_tuser   = '0;   // req_type[1:0]
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [31:0] m_tdata;          // row_out[5:0], col_out[13:6], cell_value[29:14]
	logic [1:0]  m_tuser;          // op_kind[0], trailer_mark[1]
	logic        m_tlast;
	logic        cfg_we    = 1'b0;
	logic        cfg_idx   = 1'b0;
	logic [8:0]  cfg_wdata = '0;

	int idle_pct     = 0;
	int stall_pct    = 0;
	int items_sent   = 0;
	int quiet_cycles = 0;
	int mismatches;
	int pending;

	// Line widths include values outside 2..256 to exercise the clamp
	int phase_width [NUM_PHASES] = '{2, 256, 9, 40, 17, 511, 0, 128};
	int phase_tab   [NUM_PHASES] = '{7, 0, 3, 5, 1, 6, 2, 4};
	int phase_idle  [4]          = '{0, 62, 0, 28};
	int phase_stall [4]          = '{0, 0, 62, 28};

	text_cell_expander dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	tce_cell_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_wdata  (cfg_wdata),
		.mismatches (mismatches),
		.pending    (pending)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Stall the result side at random
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	// End the run when nothing moves on either side for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Hold the request until it is taken, after an optional random gap
	task automatic send_req(input logic [1:0] req, input logic [5:0] row,
			input logic [15:0] start, input logic [15:0] code);
		while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= req;
		s_tdata  <= {2'b00, code, start, row};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (req != REQ_UNUSED) items_sent++;
	endtask

	// Wait out every owed write and the block's tail, then load both registers
	task automatic drain_and_configure(input logic [8:0] lw, input logic [2:0] toff);
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_idx   <= REG_LINE_WIDTH;
		cfg_wdata <= lw;
		@(posedge clk);
		cfg_idx   <= REG_TAB_OFFSET;
		cfg_wdata <= {6'd0, toff};
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	function automatic logic [15:0] pick_char();
		case ($urandom_range(9))
			0: return CH_TAB;
			1: return ($urandom_range(3) == 0) ? CH_DEL : 16'($urandom_range(31));
			2: return 16'($urandom_range(255, 128));
			3: return 16'($urandom_range(65535, 256));
			4: return 16'($urandom);
			default: return 16'($urandom_range(126, 32));
		endcase
	endfunction

	// A move, mostly into or near the line, a burst of characters, sometimes an erase
	task automatic send_random_line(input int w);
		logic [15:0] col;
		int          n_puts;
		case ($urandom_range(9))
			0: col = 16'($urandom);
			1: col = 16'($urandom_range(32767, 32760));
			2: col = 16'h8000 + 16'($urandom_range(7));
			default: col = 16'(int'($urandom_range(w + 13)) - 10);
		endcase
		send_req(REQ_MOVE, 6'($urandom), col, 16'($urandom));
		n_puts = $urandom_range(10, 1);
		repeat (n_puts) send_req(REQ_PUT, 6'($urandom), 16'($urandom), pick_char());
		if ($urandom_range(3) == 0)
			send_req(REQ_ERASE, 6'($urandom), 16'($urandom), 16'($urandom));
	endtask

	initial begin
		int w;
		int phase_end;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed pass at the reset settings: width 80, no tab offset
		send_req(REQ_MOVE, 6'd63, 16'hFFFD, 16'hFFFF);   // off screen left
		send_req(REQ_PUT, 6'd0, 16'h0000, 16'h0041);     // dropped
		send_req(REQ_PUT, 6'd0, 16'h0000, 16'h4E00);     // wide at negative column
		send_req(REQ_PUT, 6'd0, 16'h0000, 16'h0000);     // caret form, lowest code
		send_req(REQ_PUT, 6'd0, 16'h0000, CH_TAB);
		send_req(REQ_PUT, 6'd0, 16'h0000, 16'h001F);
		send_req(REQ_PUT, 6'd0, 16'h0000, CH_DEL);
		send_req(REQ_PUT, 6'd0, 16'h0000, CH_META);      // lowest octal escape
		send_req(REQ_PUT, 6'd0, 16'h0000, 16'h00FF);
		send_req(REQ_PUT, 6'd0, 16'h0000, 16'h007E);
		send_req(REQ_PUT, 6'd0, 16'h0000, CH_SPACE);
		send_req(REQ_PUT, 6'd0, 16'h0000, CH_WIDE);
		send_req(REQ_ERASE, 6'd0, 16'h0000, 16'h0000);
		send_req(REQ_ERASE, 6'd0, 16'h0000, 16'h0000);   // past width, nothing
		send_req(REQ_MOVE, 6'd5, 16'd78, 16'h0000);
		send_req(REQ_PUT, 6'd0, 16'h0000, 16'hFFFF);     // trailer lands in last column
		send_req(REQ_PUT, 6'd0, 16'h0000, 16'h0078);     // overflow blanks split wide char
		send_req(REQ_PUT, 6'd0, 16'h0000, CH_TAB);       // tab counted as one overflow
		send_req(REQ_MOVE, 6'd0, 16'd79, 16'h0000);
		send_req(REQ_PUT, 6'd0, 16'h0000, CH_WIDE);      // wide at last column
		send_req(REQ_MOVE, 6'd1, 16'h8000, 16'h0000);
		send_req(REQ_ERASE, 6'd0, 16'h0000, 16'h0000);   // clear from column zero
		send_req(REQ_MOVE, 6'd2, 16'h7FFF, 16'h0000);
		send_req(REQ_PUT, 6'd0, 16'h0000, 16'h0041);     // column saturates
		send_req(REQ_PUT, 6'd0, 16'h0000, 16'h0001);
		send_req(REQ_UNUSED, 6'h3F, 16'hFFFF, 16'hFFFF);
		send_req(REQ_MOVE, 6'd3, 16'd75, 16'h0000);
		send_req(REQ_PUT, 6'd0, 16'h0000, CH_TAB);       // tab up to the line end
		send_req(REQ_PUT, 6'd0, 16'h0000, 16'h009A);

		// Random phases, each with its own settings; idle and stall patterns repeat every four phases
		for (int p = 0; p < NUM_PHASES; p++) begin
			drain_and_configure(9'(phase_width[p]), 3'(phase_tab[p]));
			idle_pct  = phase_idle[p % 4];
			stall_pct = phase_stall[p % 4];
			w = (phase_width[p] < 2) ? 2 : ((phase_width[p] > 256) ? 256 : phase_width[p]);
			phase_end = items_sent + PHASE_ITEMS;
			while (items_sent < phase_end) begin
				if ($urandom_range(7) == 0)
					send_req(2'($urandom), 6'($urandom), 16'($urandom), 16'($urandom));
				else
					send_random_line(w);
			end
		end

		// Drain and give the verdict
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

FILE: files.f
rtl/core/tce_pkg.sv
rtl/core/tce_queue.sv
rtl/core/tce_front.sv
rtl/core/tce_back.sv
rtl/core/text_cell_expander.sv
test/tce_cell_checker.sv
test/tb_top.sv
